// ===== src/max_heading_change_finder_unit_defines.svh =====
// Assertion helpers shared by the heading change finder RTL.
// Both sample on clk_i and are switched off while rst_ni is low.
`ifndef MAX_HEADING_CHANGE_FINDER_UNIT_DEFINES_SVH
`define MAX_HEADING_CHANGE_FINDER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define MHCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MHCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mhcf_pkg.sv =====
package mhcf_pkg;

  // Trajectory limits and angle resolution
  localparam int unsigned MAX_POINTS = 4096;
  localparam int unsigned ANGLE_BITS = 16;

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_POINTS);

  // Coordinate difference, prescale and CORDIC word (headroom for the gain)
  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned PRESCALE = 16;
  localparam int unsigned CORDIC_W = DIFF_W + PRESCALE + 3;

  localparam int unsigned N_ITER = (ANGLE_BITS < 24) ? ANGLE_BITS : 24;
  localparam int unsigned ITER_W = $clog2(N_ITER);

  // Output field widths
  localparam int unsigned TURN_W = 16;
  localparam int unsigned AT_W = 12;

  // Turn rescaling to pi/32768 units
  localparam int unsigned TURN_SHL = (ANGLE_BITS < TURN_W) ? TURN_W - ANGLE_BITS : 0;
  localparam int unsigned TURN_SHR = (ANGLE_BITS > TURN_W) ? ANGLE_BITS - TURN_W : 0;
  localparam int unsigned SCALE_W = ANGLE_BITS + TURN_SHL;

  localparam logic [31:0] HALF_TURN_Z = 32'h8000_0000;
  localparam logic [31:0] ROUND_ADD = 32'd1 << (31 - ANGLE_BITS);
  localparam logic [ANGLE_BITS-1:0] HALF_HEAD = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_ROT,
    S_UPD
  } ctrl_state_e;

  typedef struct packed {
    logic load;    // take a request, form the coordinate differences
    logic prep;    // fold into the right half plane, seed the CORDIC
    logic rot;     // one CORDIC micro-rotation
    logic update;  // heading, turn, best tracking, result
  } dp_cmd_t;

  typedef struct packed {
    logic iter_last;
    logic last;
    logic out_busy;
  } dp_stat_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h2000_0000;
      5'd1:  v = 32'h12E4_051E;
      5'd2:  v = 32'h09FB_385B;
      5'd3:  v = 32'h0511_11D4;
      5'd4:  v = 32'h028B_0D43;
      5'd5:  v = 32'h0145_D7E1;
      5'd6:  v = 32'h00A2_F61E;
      5'd7:  v = 32'h0051_7C55;
      5'd8:  v = 32'h0028_BE53;
      5'd9:  v = 32'h0014_5F2F;
      5'd10: v = 32'h000A_2F98;
      5'd11: v = 32'h0005_17CC;
      5'd12: v = 32'h0002_8BE6;
      5'd13: v = 32'h0001_45F3;
      5'd14: v = 32'h0000_A2FA;
      5'd15: v = 32'h0000_517D;
      5'd16: v = 32'h0000_28BE;
      5'd17: v = 32'h0000_145F;
      5'd18: v = 32'h0000_0A30;
      5'd19: v = 32'h0000_0518;
      5'd20: v = 32'h0000_028C;
      5'd21: v = 32'h0000_0146;
      5'd22: v = 32'h0000_00A3;
      5'd23: v = 32'h0000_0051;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

// ===== src/mhcf_datapath.sv =====
module mhcf_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mhcf_pkg::dp_cmd_t                  cmd_i,
  output mhcf_pkg::dp_stat_t                 stat_o,
  input  logic signed [mhcf_pkg::COORD_W-1:0] x_pos_i,
  input  logic signed [mhcf_pkg::COORD_W-1:0] y_pos_i,
  input  logic                               last_point_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mhcf_pkg::TURN_W-1:0]        max_turn_o,
  output logic [mhcf_pkg::AT_W-1:0]          max_at_o,
  output logic                               too_few_points_o
);
  import mhcf_pkg::*;

  logic signed [COORD_W-1:0]  prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [ANGLE_BITS-1:0]      prev_head_q, prev_head_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [TURN_W-1:0]          best_turn_q, best_turn_d;
  logic [IDX_W-1:0]           best_idx_q, best_idx_d;

  logic signed [DIFF_W-1:0]   dx_q, dy_q;
  logic                       last_q;
  logic signed [CORDIC_W-1:0] cx_q, cy_q;
  logic [31:0]                cz_q;
  logic                       zero_q;
  logic [ITER_W-1:0]          iter_q;
  logic                       out_valid_q;

  // Fold into the right half plane
  logic                       neg;
  logic signed [DIFF_W-1:0]   ax, ay;
  // CORDIC step
  logic signed [CORDIC_W-1:0] xs, ys;
  logic [31:0]                tab;
  // Update
  logic [31:0]                z_rnd;
  logic [ANGLE_BITS-1:0]      head, diff, diff_abs;
  logic [SCALE_W-1:0]         diff_sc;
  logic [TURN_W-1:0]          turn;
  logic                       has_prev, has_two, better;
  logic [TURN_W-1:0]          nb_turn;
  logic [IDX_W-1:0]           nb_idx;
  logic [CNT_W-1:0]           cnt_inc;

  assign neg = dx_q[DIFF_W-1];
  assign ax  = neg ? -dx_q : dx_q;
  assign ay  = neg ? -dy_q : dy_q;

  assign xs  = cx_q >>> iter_q;
  assign ys  = cy_q >>> iter_q;
  assign tab = atan_entry(5'(iter_q));

  assign z_rnd    = cz_q + ROUND_ADD;
  assign head     = zero_q ? '0 : z_rnd[31 -: ANGLE_BITS];
  assign diff     = head - prev_head_q;
  assign diff_abs = (diff > HALF_HEAD) ? (~diff + ANGLE_BITS'(1)) : diff;
  assign diff_sc  = SCALE_W'(diff_abs) << TURN_SHL;
  assign turn     = TURN_W'(diff_sc >> TURN_SHR);

  assign has_prev = (cnt_q != '0);
  assign has_two  = (cnt_q >= CNT_W'(2));
  assign better   = has_two && (turn > best_turn_q);
  assign nb_turn  = better ? turn : best_turn_q;
  assign nb_idx   = better ? IDX_W'(cnt_q - CNT_W'(2)) : best_idx_q;
  assign cnt_inc  = (cnt_q < CNT_W'(MAX_POINTS)) ? cnt_q + CNT_W'(1) : cnt_q;

  always_comb begin
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    prev_head_d = prev_head_q;
    cnt_d       = cnt_q;
    best_turn_d = best_turn_q;
    best_idx_d  = best_idx_q;
    if (cmd_i.load) begin
      prev_x_d = x_pos_i;
      prev_y_d = y_pos_i;
    end
    if (cmd_i.update) begin
      if (last_q) begin
        // Trajectory done: clear for the next one
        prev_x_d    = '0;
        prev_y_d    = '0;
        prev_head_d = '0;
        cnt_d       = '0;
        best_turn_d = '0;
        best_idx_d  = '0;
      end else begin
        if (has_prev) begin
          prev_head_d = head;
        end
        cnt_d       = cnt_inc;
        best_turn_d = nb_turn;
        best_idx_d  = nb_idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_head_q <= '0;
      cnt_q       <= '0;
      best_turn_q <= '0;
      best_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      prev_head_q <= prev_head_d;
      cnt_q       <= cnt_d;
      best_turn_q <= best_turn_d;
      best_idx_q  <= best_idx_d;
      if (cmd_i.update && last_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dx_q   <= DIFF_W'(x_pos_i) - DIFF_W'(prev_x_q);
      dy_q   <= DIFF_W'(y_pos_i) - DIFF_W'(prev_y_q);
      last_q <= last_point_i;
    end
    if (cmd_i.prep) begin
      cx_q   <= {{(CORDIC_W-DIFF_W-PRESCALE){ax[DIFF_W-1]}}, ax, {PRESCALE{1'b0}}};
      cy_q   <= {{(CORDIC_W-DIFF_W-PRESCALE){ay[DIFF_W-1]}}, ay, {PRESCALE{1'b0}}};
      cz_q   <= neg ? HALF_TURN_Z : 32'h0;
      zero_q <= (dx_q == '0) && (dy_q == '0);
      iter_q <= '0;
    end
    if (cmd_i.rot) begin
      if (!cy_q[CORDIC_W-1]) begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + tab;
      end else begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - tab;
      end
      iter_q <= iter_q + ITER_W'(1);
    end
    if (cmd_i.update && last_q) begin
      if (cnt_inc < CNT_W'(3)) begin
        max_turn_o       <= '0;
        max_at_o         <= '0;
        too_few_points_o <= 1'b1;
      end else begin
        max_turn_o       <= nb_turn;
        max_at_o         <= AT_W'(nb_idx);
        too_few_points_o <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.iter_last = (iter_q == ITER_W'(N_ITER - 1));
  assign stat_o.last      = last_q;
  assign stat_o.out_busy  = out_valid_q && out_stall_i;

endmodule

// ===== src/mhcf_ctrl.sv =====
`include "max_heading_change_finder_unit_defines.svh"

module mhcf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output mhcf_pkg::dp_cmd_t   cmd_o,
  input  mhcf_pkg::dp_stat_t  stat_i
);
  import mhcf_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_ROT;
      end
      S_ROT: begin
        cmd_o.rot = 1'b1;
        if (stat_i.iter_last) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        // Hold a final point until the result register is free
        if (!(stat_i.last && stat_i.out_busy)) begin
          cmd_o.update = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `MHCF_ASSERT_NOW(a_no_result_overwrite, cmd_o.update && stat_i.last, !stat_i.out_busy, "result overwritten while stalled")
  `MHCF_ASSERT_NEXT(a_accept_starts_prep, in_valid_i && !in_stall_o, state_q == S_PREP, "accepted request did not start")
  `MHCF_ASSERT_NEXT(a_rot_ends_in_update, cmd_o.rot && stat_i.iter_last, state_q == S_UPD, "rotation count overran")

endmodule

// ===== src/max_heading_change_finder_unit.sv =====
// Largest heading change along a trajectory.
// Input channel: one request per point (x_pos_i, y_pos_i, last_point_i),
// taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: one result (max_turn_o, max_at_o, too_few_points_o) per
// trajectory, presented with the request flagged last_point_i; it is taken at
// an edge with out_valid_o high and out_stall_i low.
// Each point is taken, its segment is folded into the right half plane,
// 16 CORDIC micro-rotations run on one shared add/shift unit (ANGLE_BITS
// of them), and an update step rounds the heading, rates the turn and
// tracks the best window. A point is taken only when the one before it
// has finished its update step, which loads the result for a final point.
// While a result waits under out_stall_i, further points are still taken;
// only the next final point holds in its update step until the output
// register frees up. Reset clears the trajectory state and the output valid;
// the block takes a request in the first cycle after reset.
module max_heading_change_finder_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [mhcf_pkg::COORD_W-1:0] x_pos_i,
  input  logic signed [mhcf_pkg::COORD_W-1:0] y_pos_i,
  input  logic                               last_point_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mhcf_pkg::TURN_W-1:0]        max_turn_o,
  output logic [mhcf_pkg::AT_W-1:0]          max_at_o,
  output logic                               too_few_points_o
);
  import mhcf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence the point: take, fold, rotate, update
  mhcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  // Coordinate state, CORDIC unit, best tracking and result register
  mhcf_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .x_pos_i          (x_pos_i),
    .y_pos_i          (y_pos_i),
    .last_point_i     (last_point_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .max_turn_o       (max_turn_o),
    .max_at_o         (max_at_o),
    .too_few_points_o (too_few_points_o)
  );

endmodule

// ===== sim/max_heading_change_finder_unit_tb.sv =====
module max_heading_change_finder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mhcf_pkg::*;

  // Quiet cycles on both channels before the run is declared hung. The
  // slowest legal gap is a sender burst, the point pipeline and a receiver
  // burst.
  localparam int unsigned HANG_LIMIT = 4000;
  // Cycles to watch the output after the last result, past the point latency.
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned RANDOM_POINTS = 620;
  localparam int unsigned LONG_POINTS = 150;

  // atan(2^-i) in units of 2^-32 turn, index 0 leftmost
  localparam logic [0:23][31:0] ATAN_STEPS = {
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };
  localparam logic [ANGLE_BITS-1:0] HEAD_HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  typedef struct packed {
    logic [TURN_W-1:0] turn;
    logic [AT_W-1:0]   at;
    logic              few;
  } turn_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic signed [COORD_W-1:0] x_pos_i = '0;
  logic signed [COORD_W-1:0] y_pos_i = '0;
  logic                      last_point_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [TURN_W-1:0]         max_turn_o;
  logic [AT_W-1:0]           max_at_o;
  logic                      too_few_points_o;

  max_heading_change_finder_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .x_pos_i          (x_pos_i),
    .y_pos_i          (y_pos_i),
    .last_point_i     (last_point_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .max_turn_o       (max_turn_o),
    .max_at_o         (max_at_o),
    .too_few_points_o (too_few_points_o)
  );

  always #5 clk_i = ~clk_i;

  // Trajectory tracker state, mirrors what the block keeps between points
  longint                trk_prev_x;
  longint                trk_prev_y;
  logic [ANGLE_BITS-1:0] trk_prev_head;
  int unsigned           trk_count;
  logic [TURN_W-1:0]     trk_best_turn;
  int unsigned           trk_best_idx;

  turn_result_t pending_turns[$];

  bit          idle_en = 1'b1;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned points_sent = 0;
  int unsigned results_seen = 0;
  int unsigned few_results = 0;
  int unsigned trajectories = 0;

  function automatic void clear_track();
    trk_prev_x = 0;
    trk_prev_y = 0;
    trk_prev_head = '0;
    trk_count = 0;
    trk_best_turn = '0;
    trk_best_idx = 0;
  endfunction

  // Heading of one segment: fold into the right half plane, then rotate the
  // prescaled vector onto the x axis and sum the rotation angles.
  function automatic logic [ANGLE_BITS-1:0] segment_heading(input longint seg_dx,
                                                            input longint seg_dy);
    logic [31:0] z;
    longint      cx, cy, sx, sy;
    logic [63:0] rounded;
    int          i;
    z = '0;
    if (seg_dx == 0 && seg_dy == 0) return '0;
    if (seg_dx < 0) begin
      seg_dx = -seg_dx;
      seg_dy = -seg_dy;
      z = HALF_TURN_Z;
    end
    cx = seg_dx * 65536;
    cy = seg_dy * 65536;
    for (i = 0; i < N_ITER; i++) begin
      sx = cx >>> i;
      sy = cy >>> i;
      if (cy >= 0) begin
        cx = cx + sy;
        cy = cy - sx;
        z = z + ATAN_STEPS[i];
      end else begin
        cx = cx - sy;
        cy = cy + sx;
        z = z - ATAN_STEPS[i];
      end
    end
    rounded = ({32'd0, z} + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
    return rounded[ANGLE_BITS-1:0];
  endfunction

  // Absolute wrapped heading change, rescaled to pi/32768 units
  function automatic logic [TURN_W-1:0] heading_turn(input logic [ANGLE_BITS-1:0] h_old,
                                                     input logic [ANGLE_BITS-1:0] h_new);
    logic [ANGLE_BITS-1:0] d;
    int unsigned           dv;
    d = h_new - h_old;
    if (d > HEAD_HALF_TURN) d = -d;
    dv = 32'(d);
    if (ANGLE_BITS < TURN_W) dv = dv << (TURN_W - ANGLE_BITS);
    else dv = dv >> (ANGLE_BITS - TURN_W);
    return dv[TURN_W-1:0];
  endfunction

  // Advance the tracker by one point; return 1 with the trajectory result on
  // the final point.
  function automatic bit track_point(input logic signed [COORD_W-1:0] x,
                                     input logic signed [COORD_W-1:0] y,
                                     input logic last, output turn_result_t res);
    longint                nx, ny;
    logic [ANGLE_BITS-1:0] h;
    logic [TURN_W-1:0]     t;
    res = '0;
    nx = longint'(x);
    ny = longint'(y);
    if (trk_count >= 1) begin
      h = segment_heading(nx - trk_prev_x, ny - trk_prev_y);
      if (trk_count >= 2) begin
        t = heading_turn(trk_prev_head, h);
        // strictly larger only, so the earliest maximum is kept
        if (t > trk_best_turn) begin
          trk_best_turn = t;
          trk_best_idx = trk_count - 2;
        end
      end
      trk_prev_head = h;
    end
    trk_prev_x = nx;
    trk_prev_y = ny;
    if (trk_count < MAX_POINTS) trk_count++;
    if (!last) return 1'b0;
    if (trk_count < 3) begin
      res.few = 1'b1;
    end else begin
      res.turn = trk_best_turn;
      res.at = AT_W'(trk_best_idx);
    end
    clear_track();
    return 1'b1;
  endfunction

  // Present one point, hold it until taken, then log what it should produce.
  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y, input logic last);
    turn_result_t res;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_pos_i <= x;
    y_pos_i <= y;
    last_point_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    points_sent++;
    if (track_point(x, y, last, res)) begin
      pending_turns = {pending_turns, res};
      trajectories++;
    end
  endtask

  // Drop valid and hold the sender until every pending result is out.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (pending_turns.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [COORD_W-1:0] rand_step();
    int unsigned span;
    span = 32'd1 << $urandom_range(0, 24);
    return $signed($urandom_range(0, 2 * span)) - $signed(span);
  endfunction

  // Receiver stalls come in random bursts while idle_en is set.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare every taken result with the oldest pending one.
  always @(posedge clk_i) begin
    turn_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (too_few_points_o === 1'b1) few_results++;
      if (pending_turns.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: turn %0d at %0d few %0b",
                   max_turn_o, max_at_o, too_few_points_o);
      end else begin
        exp_r = pending_turns.pop_front();
        if (max_turn_o !== exp_r.turn || max_at_o !== exp_r.at ||
            too_few_points_o !== exp_r.few) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: turn %0d/%0d at %0d/%0d few %0b/%0b (exp/act)",
                     exp_r.turn, max_turn_o, exp_r.at, max_at_o,
                     exp_r.few, too_few_points_o);
        end
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", HANG_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Trajectories of one and two points report too few points; three collinear
  // points report no turn at all.
  task automatic test_short_trajectories();
    send_point(32'sh8000_0000, 32'sh8000_0000, 1'b1);
    send_point(32'sd0, 32'sd0, 1'b0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    send_point(32'sd0, 32'sd0, 1'b0);
    send_point(32'sd5, 32'sd0, 1'b0);
    send_point(32'sd10, 32'sd0, 1'b1);
    hold_until_drained();
  endtask

  // Corner to corner jumps give the widest coordinate differences;
  // a repeated point gives a zero length segment.
  task automatic test_extreme_coordinates();
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    send_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_point(32'sd0, 32'sd0, 1'b1);
    hold_until_drained();
  endtask

  // A full reversal gives a half turn; right-angle corners give equal turns so
  // the first window must win.
  task automatic test_turn_shapes();
    send_point(32'sd0, 32'sd0, 1'b0);
    send_point(32'sd1000, 32'sd0, 1'b0);
    send_point(32'sd0, 32'sd0, 1'b1);
    send_point(32'sd0, 32'sd0, 1'b0);
    send_point(32'sd100, 32'sd0, 1'b0);
    send_point(32'sd100, 32'sd100, 1'b0);
    send_point(-32'sd100, 32'sd100, 1'b0);
    send_point(-32'sd100, -32'sd100, 1'b1);
    hold_until_drained();
  endtask

  // A long straight run with a small early kink; the sharp turn at the end
  // must beat it with a late window index.
  task automatic test_long_trajectory();
    int i;
    for (i = 0; i < LONG_POINTS; i++)
      send_point(COORD_W'(i * 1024), (i == 10) ? 32'sd64 : 32'sd0, 1'b0);
    send_point(COORD_W'((LONG_POINTS - 1) * 1024), 32'sd5000, 1'b1);
    hold_until_drained();
  endtask

  // Random trajectories of mixed shape and length; the tail runs without
  // any idling on either side.
  task automatic test_random_trajectories(input int unsigned n_points);
    int unsigned              sent, len, pick, shape, i;
    logic signed [COORD_W-1:0] px, py, dx, dy, k;
    sent = 0;
    while (sent < n_points) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) len = $urandom_range(1, 2);
      else if (pick == 1) len = $urandom_range(50, 200);
      else len = $urandom_range(3, 30);
      shape = $urandom_range(0, 3);
      idle_en = (sent < n_points * 85 / 100) && ($urandom_range(0, 3) != 0);
      px = $urandom;
      py = $urandom;
      k = 1 << $urandom_range(0, 12);
      dx = k;
      dy = 0;
      for (i = 0; i < len; i++) begin
        case (shape)
          0: begin
            px = px + rand_step();
            py = py + rand_step();
          end
          1: begin
            px = $urandom;
            py = $urandom;
          end
          2: begin
            // walk with frequent repeated points
            if ($urandom_range(0, 2) != 0) begin
              px = px + rand_step();
              py = py + rand_step();
            end
          end
          default: begin
            // axis and diagonal moves with occasional changes of direction
            if ($urandom_range(0, 3) == 0) begin
              dx = k * ($signed($urandom_range(0, 2)) - 1);
              dy = k * ($signed($urandom_range(0, 2)) - 1);
            end
            px = px + dx;
            py = py + dy;
          end
        endcase
        send_point(px, py, i == len - 1);
        sent++;
      end
      if ($urandom_range(0, 9) == 0) hold_until_drained();
    end
    idle_en = 1'b0;
    hold_until_drained();
  endtask

  initial begin
    clear_track();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_short_trajectories();
    test_extreme_coordinates();
    test_turn_shapes();
    test_long_trajectory();
    test_random_trajectories(RANDOM_POINTS);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_turns.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", pending_turns.size());
    end
    $display("sent %0d points in %0d trajectories, checked %0d results (%0d too short)",
             points_sent, trajectories, results_seen, few_results);
    $display("covered corner coordinates, reversals, ties and a long straight trajectory");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
